// ===== hdl/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg - shared types and constants of the bitmap code allocator
// Command and status codes, map geometry, sequencer control words and the
// microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

package bca_pkg;

    // map geometry: 1024 codes, 128 rows of 8 bits, 8 groups of 16 rows
    localparam int CODE_W         = 10;
    localparam int BITS_PER_ROW   = 8;
    localparam int BIT_W          = 3;
    localparam int MAP_ROWS       = 128;
    localparam int ROW_W          = 7;
    localparam int ROWS_PER_GROUP = 16;
    localparam int IDX_W          = 4;
    localparam int GROUPS         = 8;
    localparam int GRP_W          = 3;

    localparam int S_TDATA_W = 16;  // cmd(2) code(10) pad(4)
    localparam int M_TDATA_W = 16;  // was_reserved(1) code_out(10) status(2) pad(3)

    localparam logic [BITS_PER_ROW-1:0] FULL_ROW = '1;

    typedef enum logic [1:0] {
        CMD_QUERY    = 2'd0,
        CMD_RESERVE  = 2'd1,
        CMD_FREE     = 2'd2,
        CMD_ALLOCATE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_ALREADY      = 2'd1,
        ST_NOT_RESERVED = 2'd2,
        ST_FULL         = 2'd3
    } status_t;

    // sequencer step addresses
    typedef logic [1:0] step_t;
    localparam step_t STEP_FETCH = 2'd0;
    localparam step_t STEP_CODE  = 2'd1;
    localparam step_t STEP_ROW   = 2'd2;
    localparam step_t STEP_PICK  = 2'd3;

    typedef enum logic [1:0] {
        JC_WAIT_IN  = 2'd0,   // hold until an input transfer
        JC_NEXT     = 2'd1,   // fall through
        JC_RESFREE  = 2'd2,   // jump to target on reserve or free
        JC_ALWAYS   = 2'd3    // unconditional jump to target
    } jump_t;

    typedef struct packed {
        logic  rd_code;     // read the row of the incoming code
        logic  cap_code;    // take bit of code, update map for reserve/free
        logic  grp_search;  // find first group with a free row
        logic  rd_free;     // find first free row in group, read it
        logic  pick;        // find free bit, allocate on allocate, load result
        jump_t jump;
        step_t target;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t cw;
        cw = '0;
        case (step)
            STEP_FETCH: begin
                cw.rd_code = 1'b1;
                cw.jump    = JC_WAIT_IN;
                cw.target  = STEP_FETCH;
            end
            STEP_CODE: begin
                cw.cap_code   = 1'b1;
                cw.grp_search = 1'b1;
                cw.jump       = JC_RESFREE;
                cw.target     = STEP_FETCH;
            end
            STEP_ROW: begin
                cw.rd_free = 1'b1;
                cw.jump    = JC_NEXT;
                cw.target  = STEP_FETCH;
            end
            STEP_PICK: begin
                cw.pick   = 1'b1;
                cw.jump   = JC_ALWAYS;
                cw.target = STEP_FETCH;
            end
            default: cw = '0;
        endcase
        return cw;
    endfunction

    // index of the lowest clear bit; 0 when none
    function automatic logic [BIT_W-1:0] first_zero8(input logic [7:0] v);
        logic [BIT_W-1:0] k;
        k = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!v[i]) begin
                k = BIT_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic [IDX_W-1:0] first_zero16(input logic [15:0] v);
        logic [IDX_W-1:0] k;
        k = '0;
        for (int i = 15; i >= 0; i--) begin
            if (!v[i]) begin
                k = IDX_W'(i);
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bitmap_code_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_code_allocator - 1024-code reservation map with lowest-free search
// Query, reserve, free and allocate commands over a cleared-at-reset bitmap,
// run by a four-step microprogram over one map memory.
// ----------------------------------------------------------------------------
// One command transfer in, one result transfer out. Reserve and free hold
// the sequencer for the fetch and code steps and load their result in the
// code step; query and allocate hold it for all four steps and load their
// result in the pick step: the map memory (128 rows of 8 bits, one port,
// registered read) is read once for the addressed code and once for the
// lowest free row, which a summary of per-row full flags (8 groups of 16
// rows) locates in two steps. A new command is taken once the previous
// result has been taken or is taken in the same cycle. No clearing pass
// is needed after reset: per-row valid flags make unwritten rows read as
// free.
`default_nettype none

module bitmap_code_allocator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // s_tdata: [1:0] cmd, [11:2] code, [15:12] zero
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bca_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: [0] was_reserved, [10:1] code_out, [12:11] status, [15:13] zero
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [bca_pkg::M_TDATA_W-1:0]       m_tdata
);

    // ---------------------------------------------------------------- state
    bca_pkg::step_t                       step_reg, step_next;
    bca_pkg::cmd_t                        cmd_reg, cmd_next;
    logic [bca_pkg::CODE_W-1:0]           code_reg, code_next;
    logic                                 was_reg, was_next;
    logic [bca_pkg::GRP_W-1:0]            grp_reg, grp_next;
    logic                                 all_full_reg, all_full_next;
    logic [bca_pkg::ROW_W-1:0]            free_row_reg, free_row_next;
    logic [bca_pkg::MAP_ROWS-1:0]         row_valid_reg, row_valid_next;
    logic [bca_pkg::MAP_ROWS-1:0]         row_full_reg, row_full_next;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [bca_pkg::M_TDATA_W-1:0]        m_tdata_reg, m_tdata_next;

    // map memory
    logic [bca_pkg::BITS_PER_ROW-1:0]     map_mem [bca_pkg::MAP_ROWS];
    logic [bca_pkg::BITS_PER_ROW-1:0]     rd_data_reg;
    logic                                 rd_valid_reg;
    logic                                 mem_re, mem_we;
    logic [bca_pkg::ROW_W-1:0]            mem_ra, mem_wa;
    logic [bca_pkg::BITS_PER_ROW-1:0]     mem_wd;

    // ------------------------------------------------------------- datapath
    bca_pkg::ucode_t                      cw;
    logic                                 in_xfer, is_rf, out_load;
    logic [bca_pkg::BITS_PER_ROW-1:0]     row_byte, bit_mask, new_byte;
    logic [bca_pkg::GROUPS-1:0]           grp_full;
    logic [bca_pkg::ROWS_PER_GROUP-1:0]   grp_rows;
    logic [bca_pkg::BIT_W-1:0]            free_bit;
    bca_pkg::status_t                     res_status;
    logic [bca_pkg::CODE_W-1:0]           res_code;
    logic                                 res_was;

    assign cw       = bca_pkg::ucode_rom(step_reg);
    // ready in the fetch step while the result register is free or drains this cycle
    assign s_tready = cw.rd_code && (!m_tvalid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;
    assign is_rf    = (cmd_reg == bca_pkg::CMD_RESERVE) || (cmd_reg == bca_pkg::CMD_FREE);
    assign out_load = (cw.cap_code && is_rf) || cw.pick;

    // row contents as seen by the map: unwritten rows are all free
    assign row_byte = rd_valid_reg ? rd_data_reg : '0;
    assign bit_mask = bca_pkg::BITS_PER_ROW'(1) << code_reg[bca_pkg::BIT_W-1:0];
    assign free_bit = bca_pkg::first_zero8(row_byte);

    always_comb begin
        for (int g = 0; g < bca_pkg::GROUPS; g++) begin
            grp_full[g] = &row_full_reg[g*bca_pkg::ROWS_PER_GROUP +: bca_pkg::ROWS_PER_GROUP];
        end
    end

    assign grp_rows = row_full_reg[grp_reg*bca_pkg::ROWS_PER_GROUP +: bca_pkg::ROWS_PER_GROUP];

    always_comb begin
        step_next      = step_reg;
        cmd_next       = cmd_reg;
        code_next      = code_reg;
        was_next       = was_reg;
        grp_next       = grp_reg;
        all_full_next  = all_full_reg;
        free_row_next  = free_row_reg;
        row_valid_next = row_valid_reg;
        row_full_next  = row_full_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        mem_re         = 1'b0;
        mem_ra         = '0;
        mem_we         = 1'b0;
        mem_wa         = code_reg[bca_pkg::CODE_W-1:bca_pkg::BIT_W];
        mem_wd         = '0;
        new_byte       = '0;
        res_was        = was_reg;
        res_code       = '0;
        res_status     = bca_pkg::ST_OK;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // fetch: take command, read the row of its code
        if (cw.rd_code && in_xfer) begin
            cmd_next  = bca_pkg::cmd_t'(s_tdata[1:0]);
            code_next = s_tdata[bca_pkg::CODE_W+1:2];
            mem_re    = 1'b1;
            mem_ra    = s_tdata[bca_pkg::CODE_W+1:bca_pkg::BIT_W+2];
        end

        // code row arrived: bit of code, reserve/free update
        if (cw.cap_code) begin
            res_was  = |(row_byte & bit_mask);
            was_next = res_was;
            if (cmd_reg == bca_pkg::CMD_RESERVE) begin
                if (res_was) begin
                    res_status = bca_pkg::ST_ALREADY;
                end else begin
                    new_byte = row_byte | bit_mask;
                    mem_we   = 1'b1;
                    mem_wd   = new_byte;
                    row_valid_next[mem_wa] = 1'b1;
                    row_full_next[mem_wa]  = (new_byte == bca_pkg::FULL_ROW);
                end
            end else if (cmd_reg == bca_pkg::CMD_FREE) begin
                if (!res_was) begin
                    res_status = bca_pkg::ST_NOT_RESERVED;
                end else begin
                    new_byte = row_byte & ~bit_mask;
                    mem_we   = 1'b1;
                    mem_wd   = new_byte;
                    row_valid_next[mem_wa] = 1'b1;
                    row_full_next[mem_wa]  = 1'b0;
                end
            end
        end

        // first group with a free row
        if (cw.grp_search) begin
            all_full_next = &grp_full;
            grp_next      = '0;
            for (int g = bca_pkg::GROUPS - 1; g >= 0; g--) begin
                if (!grp_full[g]) begin
                    grp_next = bca_pkg::GRP_W'(g);
                end
            end
        end

        // first free row inside that group
        if (cw.rd_free) begin
            free_row_next = {grp_reg, bca_pkg::first_zero16(grp_rows)};
            mem_re        = 1'b1;
            mem_ra        = {grp_reg, bca_pkg::first_zero16(grp_rows)};
        end

        // free row arrived: lowest free code, allocated on an allocate command
        if (cw.pick) begin
            if (all_full_reg) begin
                res_status = bca_pkg::ST_FULL;
            end else begin
                res_code = {free_row_reg, free_bit};
                if (cmd_reg == bca_pkg::CMD_ALLOCATE) begin
                    new_byte = row_byte | (bca_pkg::BITS_PER_ROW'(1) << free_bit);
                    mem_we   = 1'b1;
                    mem_wa   = free_row_reg;
                    mem_wd   = new_byte;
                    row_valid_next[free_row_reg] = 1'b1;
                    row_full_next[free_row_reg]  = (new_byte == bca_pkg::FULL_ROW);
                end
            end
            if (cmd_reg == bca_pkg::CMD_ALLOCATE) begin
                res_was = 1'b0;
            end
        end

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[0]                   = res_was;
            m_tdata_next[bca_pkg::CODE_W:1]   = res_code;
            m_tdata_next[bca_pkg::CODE_W+2:bca_pkg::CODE_W+1] = res_status;
        end

        // sequencer
        case (cw.jump)
            bca_pkg::JC_WAIT_IN: step_next = in_xfer ? step_reg + 2'd1 : step_reg;
            bca_pkg::JC_NEXT:    step_next = step_reg + 2'd1;
            bca_pkg::JC_RESFREE: step_next = is_rf ? cw.target : step_reg + 2'd1;
            bca_pkg::JC_ALWAYS:  step_next = cw.target;
            default:             step_next = bca_pkg::STEP_FETCH;
        endcase
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= bca_pkg::STEP_FETCH;
            row_valid_reg <= '0;
            row_full_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            all_full_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end else begin
            step_reg      <= step_next;
            row_valid_reg <= row_valid_next;
            row_full_reg  <= row_full_next;
            m_tvalid_reg  <= m_tvalid_next;
            all_full_reg  <= all_full_next;
            if (mem_re) begin
                rd_valid_reg <= row_valid_reg[mem_ra];
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        code_reg     <= code_next;
        was_reg      <= was_next;
        grp_reg      <= grp_next;
        free_row_reg <= free_row_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // map memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= map_mem[mem_ra];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // --------------------------------------------------------- assertions
    a_fetch_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (step_reg == bca_pkg::STEP_CODE))
        else $error("command taken outside the fetch step");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !m_tvalid_reg)
        else $error("result loaded over an untaken result");

    a_full_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (cw.pick && !all_full_reg) |-> (row_byte != bca_pkg::FULL_ROW))
        else $error("row summary says free but row is full");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_tdata_reg[bca_pkg::CODE_W+2:bca_pkg::CODE_W+1] == bca_pkg::ST_FULL))
        |-> (&row_full_reg))
        else $error("full status with a free row in the map");

endmodule

`default_nettype wire
